>>> rtl/qvr_pkg.sv
// shared widths, types, constants and register indexes of the quaternion vector rotator
package qvr_pkg;

  // field widths
  localparam int unsigned QuatW    = 18;
  localparam int unsigned QuatFrac = 16;
  localparam int unsigned VecW     = 32;

  // internal arithmetic widths
  localparam int unsigned DblW     = 2 * QuatW + 1;
  localparam int unsigned EntW     = DblW + 2;
  localparam int unsigned RndShift = 8;
  localparam int unsigned MatW     = EntW - RndShift;
  localparam int unsigned PrdW     = VecW + MatW;
  localparam int unsigned AccW     = PrdW + 1;
  localparam int unsigned OutShift = 24;
  localparam int unsigned RndW     = AccW - OutShift;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegQuatX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegQuatY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegQuatZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegQuatW = 3'd3;

  // 1.0 in the quaternion format and in the exact matrix format
  localparam logic signed [QuatW-1:0] QuatOne = QuatW'(1) << QuatFrac;
  localparam logic signed [EntW-1:0]  OneQ32  = EntW'(1) << (2 * QuatFrac);

  // rounding offsets
  localparam logic signed [EntW-1:0] EntHalf = EntW'(1) << (RndShift - 1);
  localparam logic signed [AccW-1:0] AccHalf = AccW'(1) << (OutShift - 1);

  typedef logic signed [QuatW-1:0] quat_c_t;
  typedef logic signed [VecW-1:0]  vec_c_t;
  typedef logic signed [MatW-1:0]  ent_t;
  typedef logic signed [PrdW-1:0]  prd_t;

  typedef struct packed {
    quat_c_t x;
    quat_c_t y;
    quat_c_t z;
    quat_c_t w;
  } quat_t;

  // matrix column by row, mat[col][row]
  typedef ent_t [2:0] col_t;
  typedef col_t [2:0] mat_t;

  // lane products by row, and all lanes by lane
  typedef prd_t      [2:0] lane_prd_t;
  typedef lane_prd_t [2:0] all_prd_t;

  typedef vec_c_t [2:0] vec_t;

endpackage

>>> rtl/qvr_matrix.sv
// rotation matrix builder: doubled quaternion products, then rounded matrix entries
module qvr_matrix (
  input  logic           clk_i,
  input  logic           en_i,
  input  qvr_pkg::quat_t quat_i,
  output qvr_pkg::mat_t  mat_o
);
  import qvr_pkg::*;

  typedef logic signed [DblW-1:0] dbl_t;
  typedef logic signed [EntW-1:0] ext_t;

  dbl_t xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  mat_t mat_q;

  // exact 2ab
  function automatic dbl_t dbl_mul(quat_c_t a, quat_c_t b);
    logic signed [2*QuatW-1:0] p;
    p = a * b;
    return {p, 1'b0};
  endfunction

  // round exact entry to nearest, ties up
  function automatic ent_t rnd_ent(ext_t e);
    ext_t s;
    s = (e + EntHalf) >>> RndShift;
    return MatW'(s);
  endfunction

  // doubled products stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= dbl_mul(quat_i.x, quat_i.x);
      yy_q <= dbl_mul(quat_i.y, quat_i.y);
      zz_q <= dbl_mul(quat_i.z, quat_i.z);
      xy_q <= dbl_mul(quat_i.x, quat_i.y);
      xz_q <= dbl_mul(quat_i.x, quat_i.z);
      yz_q <= dbl_mul(quat_i.y, quat_i.z);
      wx_q <= dbl_mul(quat_i.w, quat_i.x);
      wy_q <= dbl_mul(quat_i.w, quat_i.y);
      wz_q <= dbl_mul(quat_i.w, quat_i.z);
    end
  end

  // matrix entries stage, stored by column
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q[0][0] <= rnd_ent(OneQ32 - EntW'(yy_q) - EntW'(zz_q));
      mat_q[0][1] <= rnd_ent(EntW'(xy_q) + EntW'(wz_q));
      mat_q[0][2] <= rnd_ent(EntW'(xz_q) - EntW'(wy_q));
      mat_q[1][0] <= rnd_ent(EntW'(xy_q) - EntW'(wz_q));
      mat_q[1][1] <= rnd_ent(OneQ32 - EntW'(xx_q) - EntW'(zz_q));
      mat_q[1][2] <= rnd_ent(EntW'(yz_q) + EntW'(wx_q));
      mat_q[2][0] <= rnd_ent(EntW'(xz_q) + EntW'(wy_q));
      mat_q[2][1] <= rnd_ent(EntW'(yz_q) - EntW'(wx_q));
      mat_q[2][2] <= rnd_ent(OneQ32 - EntW'(xx_q) - EntW'(yy_q));
    end
  end

  assign mat_o = mat_q;

endmodule

>>> rtl/qvr_lane.sv
// one vector element times one matrix column, three products registered
module qvr_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  qvr_pkg::vec_c_t    vec_i,
  input  qvr_pkg::col_t      col_i,
  output qvr_pkg::lane_prd_t prd_o
);
  import qvr_pkg::*;

  lane_prd_t prd_d, prd_q;

  // per-row products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prd_d[r] = $signed(vec_i) * $signed(col_i[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prd_q <= prd_d;
    end
  end

  assign prd_o = prd_q;

endmodule

>>> rtl/qvr_merge.sv
// merges lane products per row, rounds, saturates and holds the output
module qvr_merge (
  input  logic              clk_i,
  input  logic              en_i,
  input  qvr_pkg::all_prd_t prd_i,
  output qvr_pkg::vec_t     rot_o
);
  import qvr_pkg::*;

  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [RndW-1:0] rnd_t;

  localparam rnd_t SatMax = {{(RndW-VecW+1){1'b0}}, {(VecW-1){1'b1}}};
  localparam rnd_t SatMin = {{(RndW-VecW+1){1'b1}}, {(VecW-1){1'b0}}};

  vec_t rot_d, rot_q;

  // sum of three lanes, round to nearest, clamp to 32 bits
  function automatic vec_c_t finish(prd_t a, prd_t b, prd_t c);
    acc_t acc;
    acc_t sh;
    rnd_t r;
    acc = AccW'(a) + AccW'(b) + AccW'(c) + AccHalf;
    sh  = acc >>> OutShift;
    r   = RndW'(sh);
    if (r > SatMax) begin
      return VecW'(SatMax);
    end else if (r < SatMin) begin
      return VecW'(SatMin);
    end
    return VecW'(r);
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rot_d[r] = finish(prd_i[0][r], prd_i[1][r], prd_i[2][r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

>>> rtl/quaternion_vector_rotator_core.sv
// pipeline: an accepted request passes the products, entries, lanes and merge stages in order to result valid
// one request per cycle while the pipe is not held; the four pipeline stages advance together
// the whole pipe holds while a result waits on the output and the sink is not ready
// reset: async active low; clears stage valid bits and loads the identity quaternion
// configuration takes effect for the first request accepted after the write edge
module quaternion_vector_rotator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qvr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qvr_pkg::QuatW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [qvr_pkg::VecW-1:0] vec_x_i,
  input  logic signed [qvr_pkg::VecW-1:0] vec_y_i,
  input  logic signed [qvr_pkg::VecW-1:0] vec_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [qvr_pkg::VecW-1:0] rot_x_o,
  output logic signed [qvr_pkg::VecW-1:0] rot_y_o,
  output logic signed [qvr_pkg::VecW-1:0] rot_z_o
);
  import qvr_pkg::*;

  quat_t    quat_q;
  vec_t     vec1_q, vec2_q;
  logic     vld1_q, vld2_q, vld3_q, vld4_q;
  logic     en;
  mat_t     mat;
  all_prd_t prd;
  vec_t     rot;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
      quat_q.w <= QuatOne;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegQuatX: quat_q.x <= cfg_wdata_i;
        RegQuatY: quat_q.y <= cfg_wdata_i;
        RegQuatZ: quat_q.z <= cfg_wdata_i;
        RegQuatW: quat_q.w <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // pipeline advances when the output slot is free or being drained
  assign en         = !vld4_q || out_ready_i;
  assign in_ready_o = en;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // vector follows the matrix pipeline for two stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      vec1_q <= {vec_z_i, vec_y_i, vec_x_i};
      vec2_q <= vec1_q;
    end
  end

  qvr_matrix u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .quat_i (quat_q),
    .mat_o  (mat)
  );

  // one lane per vector element, each with its matrix column
  for (genvar j = 0; j < 3; j++) begin : g_lane
    qvr_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .vec_i (vec2_q[j]),
      .col_i (mat[j]),
      .prd_o (prd[j])
    );
  end

  qvr_merge u_merge (
    .clk_i (clk_i),
    .en_i  (en),
    .prd_i (prd),
    .rot_o (rot)
  );

  assign out_valid_o = vld4_q;
  assign rot_x_o     = rot[0];
  assign rot_y_o     = rot[1];
  assign rot_z_o     = rot[2];

endmodule

>>> rtl/qvr_checker.sv
// port-level checker for the rotator core and its bind
module qvr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [qvr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [qvr_pkg::QuatW-1:0]    cfg_wdata_i,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic signed [qvr_pkg::VecW-1:0] vec_x_i,
  input logic signed [qvr_pkg::VecW-1:0] vec_y_i,
  input logic signed [qvr_pkg::VecW-1:0] vec_z_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [qvr_pkg::VecW-1:0] rot_x_o,
  input logic signed [qvr_pkg::VecW-1:0] rot_y_o,
  input logic signed [qvr_pkg::VecW-1:0] rot_z_o
);
  import qvr_pkg::*;

  logic       in_acc, out_acc;
  logic [2:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rot_x_o)
      && $stable(rot_y_o) && $stable(rot_z_o))
    else $error("stalled result changed");

  // an empty output slot never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with output slot empty");

  // no more requests in flight than pipeline stages
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("too many requests in flight");

  // every result comes from an accepted request
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("result without request");

endmodule

bind quaternion_vector_rotator_core qvr_checker u_qvr_checker (.*);
